FILE: hdl/pfa_pkg.sv
// Shared types and constants for the prime field arithmetic unit.
// Used by pfa_ctrl, pfa_dp and prime_field_alu; depends on nothing.
package pfa_pkg;

  localparam int ELEM_W = 31;
  localparam int CNT_W  = $clog2(ELEM_W);
  localparam logic [ELEM_W-1:0] FIELD_MODULUS_RESET = ELEM_W'(65521);

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_MUL  = 2'd1,
    CMD_AXPY = 2'd2,
    CMD_INV  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [ELEM_W-1:0] coefficient;
    logic [ELEM_W-1:0] left_operand;
    logic [ELEM_W-1:0] right_operand;
  } req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] residue;
    logic              no_inverse;
  } rsp_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_START,
    OP_RED_SAVE,
    OP_MUL_START,
    OP_EUC_INIT,
    OP_EUC_START,
    OP_EUC_UPD,
    OP_STEP_A,
    OP_STEP_B,
    OP_FINISH,
    OP_TRIVIAL
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;   // operand slot for reduction passes
  } ctrl_t;

  typedef struct packed {
    logic p_small;
    logic r1_zero;
    logic cnt_zero;
    logic out_free;
    cmd_t cmd;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_START,
    S_RED_A,
    S_RED_B,
    S_RED_SAVE,
    S_DISPATCH,
    S_MUL_START,
    S_MUL_A,
    S_MUL_B,
    S_EUC_INIT,
    S_EUC_CHK,
    S_EUC_START,
    S_EUC_A,
    S_EUC_B,
    S_EUC_UPD,
    S_DONE
  } state_t;

endpackage

FILE: hdl/pfa_dp.sv
// Datapath: modulus register, operand registers, shared bit-serial
// divide / multiply-accumulate unit, Euclid registers, result register.
// Depends on pfa_pkg.
module pfa_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [pfa_pkg::ELEM_W-1:0] cfg_write_data,
  input  pfa_pkg::req_t             in_data,
  input  pfa_pkg::ctrl_t            ctrl,
  output pfa_pkg::stat_t            stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pfa_pkg::rsp_t             out_data
);
  import pfa_pkg::*;

  logic [ELEM_W-1:0] p, a, x, y;
  logic [ELEM_W-1:0] dd, dv, ad, acc, rem;
  logic [ELEM_W-1:0] r0, r1, t0, t1;
  logic [CNT_W-1:0]  cnt;
  logic              mode, qb;
  cmd_t              cmd;

  logic [ELEM_W:0]   rem_sh, rem_sub, dbl_s;
  logic              rem_ge;
  logic [ELEM_W-1:0] acc_dbl, acc_add, t_new, raw_sel, fin_sum, fin_lhs;

  function automatic logic [ELEM_W-1:0] add_mod(input logic [ELEM_W-1:0] u,
                                                input logic [ELEM_W-1:0] v,
                                                input logic [ELEM_W-1:0] m);
    logic [ELEM_W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[ELEM_W-1:0];
  endfunction

  // shifted remainder and trial subtract (one restoring-division bit)
  assign rem_sh  = {rem, dd[cnt]};
  assign rem_ge  = rem_sh >= {1'b0, dv};
  assign rem_sub = rem_sh - {1'b0, dv};

  // accumulator doubling and conditional add, both mod p
  assign dbl_s   = {acc, 1'b0};
  assign acc_dbl = (dbl_s >= {1'b0, p}) ? dbl_s[ELEM_W-1:0] - p : dbl_s[ELEM_W-1:0];
  assign acc_add = add_mod(acc, ad, p);

  // t0 - q*t1 mod p
  assign t_new = (t0 >= acc) ? t0 - acc : t0 + (p - acc);

  // operand slot for reduction passes
  always_comb begin
    case (ctrl.idx)
      2'd0:    raw_sel = a;
      2'd1:    raw_sel = x;
      default: raw_sel = y;
    endcase
  end

  // final add for add and axpy
  assign fin_lhs = (cmd == CMD_ADD) ? x : acc;
  assign fin_sum = add_mod(fin_lhs, y, p);

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      p <= FIELD_MODULUS_RESET;
    end else if (cfg_write_en) begin
      p <= cfg_write_data;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        cmd <= in_data.command;
        a   <= in_data.coefficient;
        x   <= in_data.left_operand;
        y   <= in_data.right_operand;
      end
      OP_RED_START: begin
        dd   <= raw_sel;
        dv   <= p;
        rem  <= '0;
        acc  <= '0;
        cnt  <= CNT_W'(ELEM_W-1);
        mode <= 1'b1;
      end
      OP_RED_SAVE: begin
        case (ctrl.idx)
          2'd0:    a <= rem;
          2'd1:    x <= rem;
          default: y <= rem;
        endcase
      end
      OP_MUL_START: begin
        dd   <= (cmd == CMD_MUL) ? y : x;
        ad   <= (cmd == CMD_MUL) ? x : a;
        dv   <= p;
        rem  <= '0;
        acc  <= '0;
        cnt  <= CNT_W'(ELEM_W-1);
        mode <= 1'b0;
      end
      OP_EUC_INIT: begin
        r0 <= p;
        r1 <= a;
        t0 <= '0;
        t1 <= ELEM_W'(1);
      end
      OP_EUC_START: begin
        dd   <= r0;
        dv   <= r1;
        ad   <= t1;
        rem  <= '0;
        acc  <= '0;
        cnt  <= CNT_W'(ELEM_W-1);
        mode <= 1'b1;
      end
      OP_EUC_UPD: begin
        r0 <= r1;
        r1 <= rem;
        t0 <= t1;
        t1 <= t_new;
      end
      OP_STEP_A: begin
        rem <= rem_ge ? rem_sub[ELEM_W-1:0] : rem_sh[ELEM_W-1:0];
        qb  <= mode ? rem_ge : dd[cnt];
        acc <= acc_dbl;
      end
      OP_STEP_B: begin
        if (qb) begin
          acc <= acc_add;
        end
        if (cnt != '0) begin
          cnt <= cnt - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_FINISH || ctrl.op == OP_TRIVIAL) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_TRIVIAL) begin
      out_data.residue    <= '0;
      out_data.no_inverse <= (cmd == CMD_INV);
    end else if (ctrl.op == OP_FINISH) begin
      unique case (cmd)
        CMD_ADD, CMD_AXPY: begin
          out_data.residue    <= fin_sum;
          out_data.no_inverse <= 1'b0;
        end
        CMD_MUL: begin
          out_data.residue    <= acc;
          out_data.no_inverse <= 1'b0;
        end
        default: begin
          out_data.residue    <= (r0 == ELEM_W'(1)) ? t0 : '0;
          out_data.no_inverse <= (r0 != ELEM_W'(1));
        end
      endcase
    end
  end

  // status to controller
  assign stat.p_small  = (p < ELEM_W'(2));
  assign stat.r1_zero  = (r1 == '0);
  assign stat.cnt_zero = (cnt == '0);
  assign stat.out_free = !out_valid || out_ready;
  assign stat.cmd      = cmd;

endmodule

FILE: hdl/pfa_ctrl.sv
// Controller: sequences operand reduction, multiply passes and Euclid
// iterations on the datapath. Depends on pfa_pkg.
module pfa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pfa_pkg::stat_t stat,
  output pfa_pkg::ctrl_t ctrl
);
  import pfa_pkg::*;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  // state and slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RED_START;
          idx_next   = 2'd0;
        end
      end
      S_RED_START: state_next = stat.p_small ? S_DONE : S_RED_A;
      S_RED_A:     state_next = S_RED_B;
      S_RED_B:     state_next = stat.cnt_zero ? S_RED_SAVE : S_RED_A;
      S_RED_SAVE: begin
        if (idx == 2'd2) begin
          state_next = S_DISPATCH;
        end else begin
          state_next = S_RED_START;
          idx_next   = idx + 2'd1;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_ADD:           state_next = S_DONE;
          CMD_MUL, CMD_AXPY: state_next = S_MUL_START;
          default:           state_next = S_EUC_INIT;
        endcase
      end
      S_MUL_START: state_next = S_MUL_A;
      S_MUL_A:     state_next = S_MUL_B;
      S_MUL_B:     state_next = stat.cnt_zero ? S_DONE : S_MUL_A;
      S_EUC_INIT:  state_next = S_EUC_CHK;
      S_EUC_CHK:   state_next = stat.r1_zero ? S_DONE : S_EUC_START;
      S_EUC_START: state_next = S_EUC_A;
      S_EUC_A:     state_next = S_EUC_B;
      S_EUC_B:     state_next = stat.cnt_zero ? S_EUC_UPD : S_EUC_A;
      S_EUC_UPD:   state_next = S_EUC_CHK;
      S_DONE:      state_next = stat.out_free ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl.op  = OP_NONE;
    ctrl.idx = idx;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.op = OP_LOAD;
        end
      end
      S_RED_START: ctrl.op = OP_RED_START;
      S_RED_SAVE:  ctrl.op = OP_RED_SAVE;
      S_MUL_START: ctrl.op = OP_MUL_START;
      S_EUC_INIT:  ctrl.op = OP_EUC_INIT;
      S_EUC_START: ctrl.op = OP_EUC_START;
      S_EUC_UPD:   ctrl.op = OP_EUC_UPD;
      S_RED_A, S_MUL_A, S_EUC_A: ctrl.op = OP_STEP_A;
      S_RED_B, S_MUL_B, S_EUC_B: ctrl.op = OP_STEP_B;
      S_DONE: begin
        if (stat.out_free) begin
          ctrl.op = stat.p_small ? OP_TRIVIAL : OP_FINISH;
        end
      end
      default: ctrl.op = OP_NONE;
    endcase
  end

endmodule

FILE: hdl/prime_field_alu.sv
// Top level of the prime field arithmetic unit: controller plus datapath.
// Depends on pfa_pkg, pfa_ctrl, pfa_dp.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------
//   in       | in_valid / in_ready       | in_data  (pfa_pkg::req_t)
//   out      | out_valid / out_ready     | out_data (pfa_pkg::rsp_t)
//   cfg      | cfg_write_en              | cfg_write_data (modulus)
//
// One request at a time. Each operand is reduced by a bit-serial divider
// unless the modulus is below two. After reduction, add goes straight to the result,
// multiply and axpy run one multiply pass, inverse one divide pass per Euclid step.
// The shared divide/accumulate unit handles one bit per STEP_A/STEP_B state pair.
// Reset is synchronous and restores the modulus to 65521.
// The result register frees the input side: a new request is taken while
// an earlier result waits; a request only stalls at its end if it still waits.
module prime_field_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pfa_pkg::req_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pfa_pkg::rsp_t              out_data,
  input  logic                       cfg_write_en,
  input  logic [pfa_pkg::ELEM_W-1:0] cfg_write_data
);
  import pfa_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  pfa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_data        (in_data),
    .ctrl           (ctrl),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

FILE: sim/tb_top.sv
// Testbench for prime_field_alu: directed table plus random requests, checked
// against a behavioral modular-arithmetic predictor. Depends on pfa_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int W = ELEM_W;
  localparam int DRAIN_CYCLES = 300;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;
  logic cfg_write_en;
  logic [W-1:0] cfg_write_data;

  prime_field_alu u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit: ~420 requests under random stalls, 4 ns clock period, with margin
  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

  logic [W-1:0] modulus_q;
  rsp_t expected_q[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;

  // modular helpers on 64-bit values
  function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    logic [63:0] s;
    s = a + b;
    if (s >= p) s = s - p;
    return s;
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return (a * b) % p;  // a, b < 2^31 so the product fits
  endfunction

  // field result of one request under modulus p
  function automatic rsp_t field_result(req_t r, logic [W-1:0] pm);
    rsp_t o;
    logic [63:0] p, a, x, y, r0, r1, t0, t1, q, rn, tn, prod;
    p = pm;
    o.residue = '0;
    o.no_inverse = 1'b0;
    if (p < 2) begin
      o.no_inverse = (r.command == CMD_INV);
      return o;
    end
    a = r.coefficient % p;
    x = r.left_operand % p;
    y = r.right_operand % p;
    case (r.command)
      CMD_ADD: o.residue = W'(mod_add(x, y, p));
      CMD_MUL: o.residue = W'(mod_mul(x, y, p));
      CMD_AXPY: o.residue = W'(mod_add(mod_mul(a, x, p), y, p));
      default: begin
        // extended Euclid with Bezout coefficient kept in 0..p-1
        r0 = p; r1 = a; t0 = 0; t1 = 1;
        while (r1 != 0) begin
          q = r0 / r1;
          rn = r0 - q * r1;
          prod = mod_mul(q % p, t1, p);
          tn = (t0 >= prod) ? t0 - prod : t0 + (p - prod);
          r0 = r1; r1 = rn; t0 = t1; t1 = tn;
        end
        if (r0 == 1) o.residue = W'(t0);
        else o.no_inverse = 1'b1;
      end
    endcase
    return o;
  endfunction

  // issue one request; optional typed expectation overrides predictor
  // valid stays high after the accept until the next idle cycle or pause
  task automatic send_request(req_t r, bit has_known, rsp_t known);
    rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pred = field_result(r, modulus_q);
    if (has_known && pred !== known)
      $display("%0t predictor disagrees with table: exp %h got %h", $time, known, pred);
    expected_q.push_back(has_known ? known : pred);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [W-1:0] value);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    modulus_q = value;
  endtask

  // receiver: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: got %h", $time, out_data);
          errors++;
        end else begin
          if (out_data.residue !== expected_q[0].residue ||
              out_data.no_inverse !== expected_q[0].no_inverse) begin
            $display("%0t mismatch: expected residue %0d flag %b, got residue %0d flag %b",
                     $time, expected_q[0].residue, expected_q[0].no_inverse,
                     out_data.residue, out_data.no_inverse);
            errors++;
          end
          void'(expected_q.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [W-1:0] rand_elem(logic [W-1:0] pm);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return pm - W'(1);
    if (sel == 2) return W'($urandom);  // possibly non-canonical
    if (pm < 2) return '0;
    return W'({$urandom} % pm);
  endfunction

  typedef struct {
    req_t r;
    bit has_known;
    rsp_t known;
  } table_row_t;

  localparam logic [W-1:0] PMAX = 31'h7fffffff;
  table_row_t dir_rows[$];
  logic [W-1:0] moduli[8];

  function automatic table_row_t row(cmd_t c, logic [W-1:0] k, logic [W-1:0] x,
                                     logic [W-1:0] y, bit kn, logic [W-1:0] res, bit f);
    table_row_t t;
    t.r = '{command: c, coefficient: k, left_operand: x, right_operand: y};
    t.has_known = kn;
    t.known = '{residue: res, no_inverse: f};
    return t;
  endfunction

  initial begin
    req_t r;
    int phase;
    errors = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    modulus_q = FIELD_MODULUS_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset modulus 65521
    dir_rows.push_back(row(CMD_ADD, 0, 0, 0, 1, 0, 0));
    dir_rows.push_back(row(CMD_ADD, 0, 65520, 1, 1, 0, 0));
    dir_rows.push_back(row(CMD_ADD, 0, 65520, 65520, 1, 65519, 0));
    dir_rows.push_back(row(CMD_MUL, 0, 65520, 65520, 1, 1, 0));
    dir_rows.push_back(row(CMD_MUL, 0, 0, 65520, 1, 0, 0));
    dir_rows.push_back(row(CMD_AXPY, 65520, 1, 1, 1, 0, 0));
    dir_rows.push_back(row(CMD_AXPY, 3, 7, 5, 1, 26, 0));
    dir_rows.push_back(row(CMD_INV, 0, 0, 0, 1, 0, 1));
    dir_rows.push_back(row(CMD_INV, 1, 0, 0, 1, 1, 0));
    dir_rows.push_back(row(CMD_INV, 65520, 0, 0, 1, 65520, 0));
    dir_rows.push_back(row(CMD_INV, 65521, 0, 0, 1, 0, 1));
    dir_rows.push_back(row(CMD_INV, 12345, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_ADD, 0, PMAX, PMAX, 0, 0, 0));
    dir_rows.push_back(row(CMD_AXPY, PMAX, PMAX, PMAX, 0, 0, 0));
    dir_rows.push_back(row(CMD_MUL, 0, 31'h2aaaaaaa, 31'h55555555, 0, 0, 0));
    foreach (dir_rows[i]) send_request(dir_rows[i].r, dir_rows[i].has_known, dir_rows[i].known);

    // composite modulus: gcd not one, and modulus below two
    write_modulus(31'd12);
    send_request('{command: CMD_INV, coefficient: 31'd4, left_operand: '0, right_operand: '0},
                 1, '{residue: '0, no_inverse: 1'b1});
    send_request('{command: CMD_INV, coefficient: 31'd5, left_operand: '0, right_operand: '0},
                 1, '{residue: 31'd5, no_inverse: 1'b0});
    write_modulus(31'd1);
    send_request('{command: CMD_INV, coefficient: 31'd1, left_operand: '0, right_operand: '0},
                 1, '{residue: '0, no_inverse: 1'b1});
    send_request('{command: CMD_ADD, coefficient: PMAX, left_operand: PMAX, right_operand: 31'd9},
                 1, '{residue: '0, no_inverse: 1'b0});
    write_modulus(31'd0);
    send_request('{command: CMD_MUL, coefficient: '0, left_operand: 31'd3, right_operand: 31'd9},
                 1, '{residue: '0, no_inverse: 1'b0});

    // random phases across moduli and idling profiles
    moduli = '{31'd2, 31'd3, 31'd65521, 31'h7fffffff, 31'd1000003, 31'd91, 31'd2, 31'h7fffffff};
    for (phase = 0; phase < 8; phase++) begin
      write_modulus(phase == 5 ? moduli[5] : (phase == 6 ? W'($urandom) | 31'h1 : moduli[phase]));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int n = 0; n < 50; n++) begin
        r.command = cmd_t'($urandom_range(3));
        r.coefficient = rand_elem(modulus_q);
        r.left_operand = rand_elem(modulus_q);
        r.right_operand = rand_elem(modulus_q);
        send_request(r, 0, '0);
        // one pause until every result is back
        if (phase == 3 && n == 25) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (expected_q.size() != 0);
        end
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pfa_pkg.sv
hdl/pfa_dp.sv
hdl/pfa_ctrl.sv
hdl/prime_field_alu.sv
sim/tb_top.sv
